FILE: hdl/pf32_pkg.sv
`timescale 1ns / 1ps

package pf32_pkg;

  typedef enum logic [3:0] {
    FMT_BGR24  = 4'd0,
    FMT_RGB24  = 4'd1,
    FMT_BGR32  = 4'd2,
    FMT_RGB32  = 4'd3,
    FMT_YUYV   = 4'd4,
    FMT_UYVY   = 4'd5,
    FMT_RGB565 = 4'd6,
    FMT_RGB555 = 4'd7,
    FMT_GREY   = 4'd8
  } fmt_t;

  localparam int SumWidth = 22;

  localparam logic signed [SumWidth-1:0] CoefBU = 22'sd2078;
  localparam logic signed [SumWidth-1:0] CoefGU = 22'sd406;
  localparam logic signed [SumWidth-1:0] CoefGV = 22'sd595;
  localparam logic signed [SumWidth-1:0] CoefRV = 22'sd1167;
  localparam logic signed [8:0] ChromaOffset = 9'sd128;

  typedef logic signed [SumWidth-1:0] sum_t;

  function automatic logic [7:0] clamp_q10(input sum_t s);
    logic [7:0] r;
    if (s[SumWidth-1]) begin
      r = 8'd0;
    end else if (|s[SumWidth-2:18]) begin
      r = 8'hff;
    end else begin
      r = s[17:10];
    end
    return r;
  endfunction

endpackage

FILE: hdl/pixel_format_to_32bit.sv
`timescale 1ns / 1ps

// Converts packed source pixel groups into 32-bit pixels.
// The input channel (in_valid, in_stall) carries one group of up to four bytes,
// byte 0 in the low bits, and an image end flag. The output channel
// (out_valid, out_stall) carries one pixel per beat as four bytes plus the
// group_last and image_last flags.
// The source format is set through the write channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high and the format should be changed only
// while no group is in flight.
// An accepted group waits in the input register and is loaded into the result
// register once the output beat is empty or not stalled.
// One group is taken every cycle while the output is not stalled for the copy,
// grey and 16-bit formats; the YUYV and UYVY formats give two pixels per group,
// which leave in turn through the single result register.
// Reset clears the valid flags of both pipeline registers and sets the format to BGR24.
// When the receiver stalls, the output beat holds, the held group waits in
// the input register and in_stall rises once that register is occupied.
module pixel_format_to_32bit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] source_group,
  input  logic        image_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic        group_last,
  output logic        image_last
);
  import pf32_pkg::*;

  logic [3:0]  fmt;
  logic        iv;
  logic [31:0] igroup;
  logic        iend;
  logic        ipix;

  logic [7:0] b0, b1, b2, b3;
  logic       is_yuv;
  logic       out_load;
  logic       item_done;
  logic       in_accept;

  logic [7:0] yy8, uu8, vv8;
  logic signed [8:0] du, dv;
  sum_t yy, sum_b, sum_g, sum_r;

  logic [7:0] p0, p1, p2, p3;
  logic       glast;

  assign cfg_ready = 1'b1;

  assign b0 = igroup[7:0];
  assign b1 = igroup[15:8];
  assign b2 = igroup[23:16];
  assign b3 = igroup[31:24];

  assign is_yuv    = (fmt == FMT_YUYV) || (fmt == FMT_UYVY);
  assign out_load  = iv && (!out_valid || !out_stall);
  assign item_done = out_load && (!is_yuv || ipix);
  assign in_stall  = iv && !item_done;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (fmt == FMT_UYVY) begin
      yy8 = ipix ? b3 : b1;
      uu8 = b0;
      vv8 = b2;
    end else begin
      yy8 = ipix ? b2 : b0;
      uu8 = b1;
      vv8 = b3;
    end
  end

  assign du = $signed({1'b0, uu8}) - ChromaOffset;
  assign dv = $signed({1'b0, vv8}) - ChromaOffset;
  assign yy = $signed({4'b0, yy8, 10'b0});

  assign sum_b = yy + CoefBU * SumWidth'(du);
  assign sum_g = yy - CoefGU * SumWidth'(du) - CoefGV * SumWidth'(dv);
  assign sum_r = yy + CoefRV * SumWidth'(dv);

  always_comb begin
    p3    = 8'd0;
    glast = 1'b1;
    case (fmt)
      FMT_BGR24, FMT_BGR32: begin
        p0 = b2;
        p1 = b1;
        p2 = b0;
      end
      FMT_RGB24: begin
        p0 = b0;
        p1 = b1;
        p2 = b2;
      end
      FMT_RGB32: begin
        p0 = b0;
        p1 = b1;
        p2 = b2;
        p3 = b3;
      end
      FMT_YUYV, FMT_UYVY: begin
        p0    = clamp_q10(sum_b);
        p1    = clamp_q10(sum_g);
        p2    = clamp_q10(sum_r);
        glast = ipix;
      end
      FMT_RGB565: begin
        p0 = {b0[4:0], b0[2:0]};
        p1 = {b1[2:0], b0[7:5], b0[6:5]};
        p2 = {b1[7:3], b1[5:3]};
      end
      FMT_RGB555: begin
        p0 = {b0[4:0], b0[2:0]};
        p1 = {b1[1:0], b0[7:5], b0[7:5]};
        p2 = {b1[6:2], b1[4:2]};
      end
      FMT_GREY: begin
        p0 = b0;
        p1 = b0;
        p2 = b0;
      end
      default: begin
        p0 = 8'd0;
        p1 = 8'd0;
        p2 = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_BGR24;
    end else if (cfg_valid && cfg_ready) begin
      fmt <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv   <= 1'b0;
      ipix <= 1'b0;
    end else begin
      if (in_accept) begin
        iv   <= 1'b1;
        ipix <= 1'b0;
      end else if (item_done) begin
        iv   <= 1'b0;
        ipix <= 1'b0;
      end else if (out_load && is_yuv) begin
        ipix <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      igroup <= source_group;
      iend   <= image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte0  <= p0;
      out_byte1  <= p1;
      out_byte2  <= p2;
      out_byte3  <= p3;
      group_last <= glast;
      image_last <= glast && iend;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !iv |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_second_pixel_held: assert property (@(posedge clk) disable iff (rst)
    ipix |-> (iv && is_yuv))
    else $error("second pixel pending without a held yuv group");

  a_first_pixel_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !group_last) |-> !image_last)
    else $error("image end flagged on the first pixel of a pair");

  a_done_moves_out: assert property (@(posedge clk) disable iff (rst)
    item_done |=> out_valid)
    else $error("group retired without an output beat");

endmodule
